[design/kcsm_pkg.sv]
// Shared types, keysym codes and FSM states for the key chord sequence matcher.
// No dependencies.
`default_nettype none

package kcsm_pkg;

  localparam int DEF_MAX_BINDINGS   = 16;
  localparam int DEF_MAX_CHORD_KEYS = 4;

  // item command codes
  localparam logic CMD_KEY   = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [31:0] KEYSYM_SHIFT_L   = 32'h0000_ffe1;
  localparam logic [31:0] KEYSYM_SHIFT_R   = 32'h0000_ffe2;
  localparam logic [31:0] KEYSYM_CONTROL_L = 32'h0000_ffe3;
  localparam logic [31:0] KEYSYM_CONTROL_R = 32'h0000_ffe4;
  localparam logic [31:0] KEYSYM_CAPS_LOCK = 32'h0000_ffe5;
  localparam logic [31:0] KEYSYM_ALT_L     = 32'h0000_ffe9;
  localparam logic [31:0] KEYSYM_ALT_R     = 32'h0000_ffea;
  localparam logic [31:0] KEYSYM_SUPER_L   = 32'h0000_ffeb;
  localparam logic [31:0] KEYSYM_SUPER_R   = 32'h0000_ffec;
  localparam logic [31:0] KEYSYM_VT_FIRST  = 32'h1008_fe01;
  localparam logic [31:0] KEYSYM_VT_LAST   = 32'h1008_fe0c;
  localparam logic [7:0]  MOD_CTRL_ALT     = 8'h0c;

  typedef struct packed {
    logic        command;
    logic        pressed;
    logic [31:0] keysym;
    logic [7:0]  modifier_mask;
    logic [3:0]  binding_slot;
    logic [1:0]  key_position;
    logic [2:0]  binding_length;
    logic        binding_active;
  } kcsm_item_t;

  typedef struct packed {
    logic       forward_key;
    logic       action_fired;
    logic [3:0] action_index;
    logic [3:0] vt_number;
    logic       prefix_changed;
    logic [1:0] prefix_length;
  } kcsm_result_t;

  // one key word of a binding: keysym plus modifier mask
  typedef struct packed {
    logic [31:0] sym;
    logic [7:0]  mods;
  } kcsm_key_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BIND,
    ST_CMP
  } kcsm_state_t;

  function automatic logic is_modifier_sym(input logic [31:0] s);
    return (s == KEYSYM_SUPER_L) || (s == KEYSYM_SUPER_R) || (s == KEYSYM_ALT_L) ||
           (s == KEYSYM_ALT_R) || (s == KEYSYM_SHIFT_L) || (s == KEYSYM_SHIFT_R) ||
           (s == KEYSYM_CONTROL_L) || (s == KEYSYM_CONTROL_R) ||
           (s == KEYSYM_CAPS_LOCK);
  endfunction

endpackage

`default_nettype wire

[design/kcsm_key_ram.sv]
// Binding key word store: one write port, one registered read port, and an
// equality check of the read word. Uses kcsm_pkg.
`default_nettype none

module kcsm_key_ram
  import kcsm_pkg::*;
#(
  parameter  int DEPTH  = DEF_MAX_BINDINGS * DEF_MAX_CHORD_KEYS,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire kcsm_key_t         wr_word,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  input  wire kcsm_key_t         cmp_word,
  output logic                   hit
);

  kcsm_key_t mem [DEPTH];
  kcsm_key_t rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // compare word is presented in the cycle the read data arrives
  assign hit = (rd_data == cmp_word);

endmodule

`default_nettype wire

[design/key_chord_sequence_matcher.sv]
// Key chord sequence matcher top level: FSM walking the binding table,
// prefix registers and result register. Uses kcsm_pkg and kcsm_key_ram.
`default_nettype none

// Results: table writes, key releases and absorbed modifiers give their result
//   in the cycle after start. A key press walks the bindings in table order:
//   each binding visited gets a header check in ST_BIND, then ST_CMP compares
//   its key words (prefix, then key) while they match; then the result follows.
// Items: one at a time; busy stays high for the walk, which is set by
//   the single read port of the key word memory (one word per cycle).
// Reset (rst, sync): all bindings inactive, prefix empty, VT switching off.
//   The key word memory and lengths are not cleared; writes load them.
// Results appear for one cycle with done; the receiver cannot stall.
module key_chord_sequence_matcher
  import kcsm_pkg::*;
#(
  parameter int MAX_BINDINGS   = DEF_MAX_BINDINGS,
  parameter int MAX_CHORD_KEYS = DEF_MAX_CHORD_KEYS
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire kcsm_item_t   item,
  output logic              busy,
  output kcsm_result_t      result,
  output logic              done,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic         cfg_data
);

  localparam int DEPTH     = MAX_BINDINGS * MAX_CHORD_KEYS;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int BIDX_W    = (MAX_BINDINGS > 1) ? $clog2(MAX_BINDINGS) : 1;
  localparam int CNT_W     = $clog2(MAX_CHORD_KEYS);
  localparam int LEN_W     = $clog2(MAX_CHORD_KEYS + 1);
  localparam int CNT_EXT_W = (CNT_W > 2) ? CNT_W : 2;
  localparam int IDX_EXT_W = (BIDX_W > 4) ? BIDX_W : 4;

  kcsm_state_t state, state_next;

  // configuration register
  logic vt_en;

  // per-binding header: active flags (reset) and clamped lengths (no reset)
  logic             active  [MAX_BINDINGS];
  logic [LEN_W-1:0] lengths [MAX_BINDINGS];

  // chord prefix; the last entry is never written (a full prefix fires)
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  kcsm_key_t        prefix [MAX_CHORD_KEYS];

  // walk registers
  logic [BIDX_W-1:0] b;
  logic [ADDR_W-1:0] base;
  logic [CNT_W-1:0]  j;
  kcsm_key_t         key;

  kcsm_result_t result_next;
  logic         done_next;
  logic         prefix_wr;

  // control
  logic              accept;
  logic              is_write;
  logic              goes_search;
  logic              wr_ok;
  logic              qualify;
  logic              last;
  logic              at_end;
  logic              advance;
  logic              finish_hit;
  logic              finish_miss;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [LEN_W-1:0]  len_clamped;
  kcsm_key_t         cmp_word;
  kcsm_key_t         wr_word;
  logic              hit;

  logic [CNT_EXT_W-1:0] cnt_ext;
  logic [IDX_EXT_W-1:0] idx_ext;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign is_write  = (item.command == CMD_WRITE);
  // a press that is not an absorbed modifier starts the table walk
  assign goes_search = (item.command == CMD_KEY) && item.pressed &&
                       !((cnt != '0) && is_modifier_sym(item.keysym));

  // out-of-range slot or position writes are dropped
  assign wr_ok = (32'(item.binding_slot) < MAX_BINDINGS) &&
                 (32'(item.key_position) < MAX_CHORD_KEYS);
  assign wr_addr = ADDR_W'(32'(item.binding_slot) * MAX_CHORD_KEYS +
                           32'(item.key_position));
  assign len_clamped = (32'(item.binding_length) > MAX_CHORD_KEYS) ?
                       LEN_W'(MAX_CHORD_KEYS) : LEN_W'(item.binding_length);
  assign wr_word = '{sym: item.keysym, mods: item.modifier_mask};

  // word j of a binding is checked against the prefix, the last one against the key
  assign cmp_word = (j < cnt) ? prefix[j] : key;

  kcsm_key_ram #(
    .DEPTH (DEPTH)
  ) u_key_ram (
    .clk      (clk),
    .wr_en    (accept && is_write && wr_ok),
    .wr_addr  (wr_addr),
    .wr_word  (wr_word),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .cmp_word (cmp_word),
    .hit      (hit)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && goes_search) state_next = ST_BIND;
      end
      ST_BIND: begin
        if (qualify)   state_next = ST_CMP;
        else if (last) state_next = ST_IDLE;
      end
      ST_CMP: begin
        if (hit && at_end)  state_next = ST_IDLE;
        else if (!hit) state_next = last ? ST_IDLE : ST_BIND;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    busy        = (state != ST_IDLE);
    qualify     = active[b] && (32'(lengths[b]) > 32'(cnt));
    last        = (32'(b) == MAX_BINDINGS - 1);
    at_end      = (j == cnt);
    advance     = 1'b0;
    finish_hit  = 1'b0;
    finish_miss = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = base;
    case (state)
      ST_IDLE: ;
      ST_BIND: begin
        if (qualify) begin
          rd_en = 1'b1;
        end else begin
          advance     = !last;
          finish_miss = last;
        end
      end
      ST_CMP: begin
        if (hit && at_end) begin
          finish_hit = 1'b1;
        end else if (hit) begin
          rd_en   = 1'b1;
          rd_addr = base + ADDR_W'(j) + ADDR_W'(1);
        end else begin
          advance     = !last;
          finish_miss = last;
        end
      end
      default: ;
    endcase
  end

  // result of the item that ends this cycle
  always_comb begin
    result_next = '0;
    done_next   = 1'b0;
    cnt_next    = cnt;
    prefix_wr   = 1'b0;
    idx_ext     = IDX_EXT_W'(b);
    if (state == ST_IDLE && accept && !goes_search) begin
      done_next = 1'b1;
      result_next.forward_key = !is_write && !item.pressed;
    end
    if (finish_hit) begin
      done_next = 1'b1;
      if (32'(lengths[b]) == 32'(cnt) + 1) begin
        result_next.action_fired = 1'b1;
        result_next.action_index = idx_ext[3:0];
        cnt_next = '0;
      end else if (32'(cnt) < MAX_CHORD_KEYS - 1) begin
        prefix_wr = 1'b1;
        cnt_next  = cnt + CNT_W'(1);
      end
    end
    if (finish_miss) begin
      done_next = 1'b1;
      if (cnt != '0) begin
        cnt_next = '0;  // mismatch drops the chord, key absorbed
      end else if (vt_en && key.mods == MOD_CTRL_ALT &&
                   key.sym >= KEYSYM_VT_FIRST && key.sym <= KEYSYM_VT_LAST) begin
        result_next.vt_number = 4'(key.sym - KEYSYM_VT_FIRST + 32'd1);
      end else begin
        result_next.forward_key = 1'b1;
      end
    end
    cnt_ext = CNT_EXT_W'(cnt_next);
    result_next.prefix_changed = (cnt_next != cnt);
    result_next.prefix_length  = cnt_ext[1:0];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      vt_en <= 1'b0;
      cnt   <= '0;
      done  <= 1'b0;
      for (int i = 0; i < MAX_BINDINGS; i++) begin
        active[i] <= 1'b0;
      end
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= done_next;
      if (cfg_valid && cfg_ready) begin
        vt_en <= cfg_data;
      end
      if (accept && is_write && wr_ok) begin
        active[BIDX_W'(item.binding_slot)] <= item.binding_active;
      end
    end
  end

  // payload and walk registers
  always_ff @(posedge clk) begin
    result <= result_next;
    if (accept && is_write && wr_ok) begin
      lengths[BIDX_W'(item.binding_slot)] <= len_clamped;
    end
    if (prefix_wr) begin
      prefix[cnt] <= key;
    end
    if (accept) begin
      key  <= '{sym: item.keysym, mods: item.modifier_mask};
      b    <= '0;
      base <= '0;
      j    <= '0;
    end else if (advance) begin
      b    <= b + BIDX_W'(1);
      base <= base + ADDR_W'(MAX_CHORD_KEYS);
      j    <= '0;
    end else if (state == ST_CMP && hit) begin
      j <= j + CNT_W'(1);
    end
  end

`ifndef SYNTH
  // a result is only shown once the walk is over
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // every accepted item is either walking or answered next cycle
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy || done))
    else $error("accepted item produced neither walk nor result");

  // firing a binding always empties the chord
  a_fire_clears: assert property (@(posedge clk) disable iff (rst)
    (done && result.action_fired) |-> (result.prefix_length == 2'd0 &&
                                       !result.forward_key &&
                                       result.vt_number == 4'd0))
    else $error("fired binding left prefix or other action");

  // the prefix never reaches a full chord
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    32'(cnt) < MAX_CHORD_KEYS)
    else $error("prefix count out of range");

  // prefix only moves when an item ends
  a_cnt_stable: assert property (@(posedge clk) disable iff (rst)
    !done_next |=> $stable(cnt))
    else $error("prefix count changed mid walk");
`endif

endmodule

`default_nettype wire
